### hdl/bcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded circular deque package
// Shared widths, operation codes and memory request type for the deque.
// ----------------------------------------------------------------------------
package bcd_pkg;

    // Ring geometry
    localparam int DEPTH  = 1024;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 11;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int EFF_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;

    typedef logic signed [DATA_W-1:0] value_t;

    // Reported for both ends while the deque is empty
    localparam value_t EMPTY_VALUE = -32'sd1;

    // Operation codes carried in the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT,
        MODE_PUSH_BACK,
        MODE_POP_FRONT,
        MODE_POP_BACK,
        MODE_QUERY
    } mode_t;

    // One write and one read of the ring per cycle
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        value_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

### hdl/bcd_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded circular deque channels
// Valid/ready channels for operation requests, results and capacity writes.
// ----------------------------------------------------------------------------
interface bcd_req_if;
    import bcd_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    value_t              push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink   (input valid, input mode, input push_value, output ready);
endinterface

interface bcd_rsp_if;
    import bcd_pkg::*;

    logic   valid;
    logic   ready;
    logic   accepted;
    value_t front_value;
    value_t rear_value;
    logic   is_empty;
    logic   is_full;

    modport source (output valid, output accepted, output front_value,
                    output rear_value, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input accepted, input front_value,
                    input rear_value, input is_empty, input is_full,
                    output ready);
endinterface

interface bcd_cfg_if;
    import bcd_pkg::*;

    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/bounded_circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded circular deque
// Double-ended queue of signed 32-bit values held in a ring memory.
// ----------------------------------------------------------------------------
// Each request is one operation (push front, push back, pop front, pop back
// or query) and returns one result: whether it was accepted, the front and
// rear values afterwards (-1 when empty) and the empty and full flags. A
// request is taken, the indices and count are updated and the ring memory
// is written or read; then, once the result register is free, the
// registered read data is loaded into the result register. A new request
// is taken once that result is loaded, while the result still waits on its
// own channel; a stalled result channel delays that load.
// The capacity is saturated to the ring depth of 1024, a value of zero
// refuses every push, and a capacity write keeps the stored entries.
module bounded_circular_deque (
    input  logic       clk,
    input  logic       rst_n,
    bcd_cfg_if.sink    cfg,
    bcd_req_if.sink    req,
    bcd_rsp_if.source  rsp
);
    import bcd_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    ram_req_t         mem_req;
    value_t           rd_data;

    // Capacity register, always ready for a write
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(1024);
        end
        else if (cfg.valid && cfg.ready)
        begin
            capacity_reg <= cfg.data;
        end
    end

    // Controller
    bcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .req      (req),
        .rsp      (rsp),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    // Ring store
    bcd_ring_ram u_ram (
        .clk     (clk),
        .mem_req (mem_req),
        .rd_data (rd_data)
    );

endmodule

### hdl/bcd_ring_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque ring store
// Single write port, single read port, registered read.
// ----------------------------------------------------------------------------
module bcd_ring_ram (
    input  logic              clk,
    input  bcd_pkg::ram_req_t mem_req,
    output bcd_pkg::value_t   rd_data
);
    import bcd_pkg::*;

    value_t mem [DEPTH];

    // Write the pushed entry, register the requested entry
    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        if (mem_req.re)
        begin
            rd_data <= mem[mem_req.raddr];
        end
    end

endmodule

### hdl/bcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque controller
// Index and count update, ring access issue, end value cache and result
// register.
// ----------------------------------------------------------------------------
module bcd_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [bcd_pkg::CAP_W-1:0] capacity,
    bcd_req_if.sink                   req,
    bcd_rsp_if.source                 rsp,
    output bcd_pkg::ram_req_t         mem_req,
    input  bcd_pkg::value_t           rd_data
);
    import bcd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RESP
    } state_t;

    state_t           state_reg,     state_next;
    logic [IDX_W-1:0] front_idx_reg, front_idx_next;
    logic [IDX_W-1:0] rear_idx_reg,  rear_idx_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    value_t           front_val_reg, front_val_next;
    value_t           rear_val_reg,  rear_val_next;
    logic             acc_reg,       acc_next;
    logic             ref_front_reg, ref_front_next;
    logic             ref_rear_reg,  ref_rear_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_acc_reg,   out_acc_next;
    value_t           out_front_reg, out_front_next;
    value_t           out_rear_reg,  out_rear_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_full_reg,  out_full_next;

    logic [EFF_W-1:0] cap_ext;
    logic [EFF_W-1:0] eff_cap;
    logic             full_now;
    logic             empty_now;
    logic             accept;
    logic             slot_free;
    logic [IDX_W-1:0] front_prev;
    logic [IDX_W-1:0] front_succ;
    logic [IDX_W-1:0] rear_prev;
    logic [IDX_W-1:0] rear_succ;

    // Saturate capacity to the ring depth
    assign cap_ext   = EFF_W'(capacity);
    assign eff_cap   = (cap_ext > EFF_W'(DEPTH)) ? EFF_W'(DEPTH) : cap_ext;
    assign full_now  = EFF_W'(count_reg) >= eff_cap;
    assign empty_now = (count_reg == '0);

    // Ring neighbours of both ends
    assign front_prev = (front_idx_reg == '0) ? IDX_W'(DEPTH - 1) : front_idx_reg - 1'b1;
    assign front_succ = (front_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : front_idx_reg + 1'b1;
    assign rear_prev  = (rear_idx_reg == '0) ? IDX_W'(DEPTH - 1) : rear_idx_reg - 1'b1;
    assign rear_succ  = (rear_idx_reg == IDX_W'(DEPTH - 1)) ? '0 : rear_idx_reg + 1'b1;

    // Handshakes
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = out_acc_reg;
    assign rsp.front_value = out_front_reg;
    assign rsp.rear_value  = out_rear_reg;
    assign rsp.is_empty    = out_empty_reg;
    assign rsp.is_full     = out_full_reg;

    // Next state: execute the request on accept, publish the result after
    // the ring read returns
    always_comb
    begin
        state_next     = state_reg;
        front_idx_next = front_idx_reg;
        rear_idx_next  = rear_idx_reg;
        count_next     = count_reg;
        front_val_next = front_val_reg;
        rear_val_next  = rear_val_reg;
        acc_next       = acc_reg;
        ref_front_next = ref_front_reg;
        ref_rear_next  = ref_rear_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_acc_next   = out_acc_reg;
        out_front_next = out_front_reg;
        out_rear_next  = out_rear_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;

        mem_req.we    = 1'b0;
        mem_req.waddr = front_idx_reg;
        mem_req.wdata = req.push_value;
        mem_req.re    = 1'b0;
        mem_req.raddr = front_succ;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_RESP;
                    acc_next       = 1'b0;
                    ref_front_next = 1'b0;
                    ref_rear_next  = 1'b0;
                    unique case (req.mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK:
                        begin
                            if (!full_now)
                            begin
                                acc_next   = 1'b1;
                                count_next = count_reg + 1'b1;
                                mem_req.we = 1'b1;
                                if (empty_now)
                                begin
                                    rear_idx_next  = front_idx_reg;
                                    mem_req.waddr  = front_idx_reg;
                                    front_val_next = req.push_value;
                                    rear_val_next  = req.push_value;
                                end
                                else if (req.mode == MODE_PUSH_FRONT)
                                begin
                                    front_idx_next = front_prev;
                                    mem_req.waddr  = front_prev;
                                    front_val_next = req.push_value;
                                end
                                else
                                begin
                                    rear_idx_next = rear_succ;
                                    mem_req.waddr = rear_succ;
                                    rear_val_next = req.push_value;
                                end
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_BACK:
                        begin
                            if (!empty_now)
                            begin
                                acc_next   = 1'b1;
                                count_next = count_reg - 1'b1;
                                if (count_reg != CNT_W'(1))
                                begin
                                    mem_req.re = 1'b1;
                                    if (req.mode == MODE_POP_FRONT)
                                    begin
                                        front_idx_next = front_succ;
                                        mem_req.raddr  = front_succ;
                                        ref_front_next = 1'b1;
                                    end
                                    else
                                    begin
                                        rear_idx_next = rear_prev;
                                        mem_req.raddr = rear_prev;
                                        ref_rear_next = 1'b1;
                                    end
                                end
                            end
                        end
                        MODE_QUERY:
                        begin
                            acc_next = 1'b1;
                        end
                        default:
                        begin
                            acc_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_RESP:
            begin
                if (slot_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    out_acc_next   = acc_reg;
                    out_empty_next = empty_now;
                    out_full_next  = full_now;
                    if (ref_front_reg)
                    begin
                        front_val_next = rd_data;
                    end
                    if (ref_rear_reg)
                    begin
                        rear_val_next = rd_data;
                    end
                    out_front_next = empty_now ? EMPTY_VALUE
                                   : (ref_front_reg ? rd_data : front_val_reg);
                    out_rear_next  = empty_now ? EMPTY_VALUE
                                   : (ref_rear_reg ? rd_data : rear_val_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state, indices, cached ends and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_idx_reg <= '0;
            rear_idx_reg  <= '0;
            count_reg     <= '0;
            front_val_reg <= EMPTY_VALUE;
            rear_val_reg  <= EMPTY_VALUE;
            acc_reg       <= 1'b0;
            ref_front_reg <= 1'b0;
            ref_rear_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_acc_reg   <= 1'b0;
            out_front_reg <= EMPTY_VALUE;
            out_rear_reg  <= EMPTY_VALUE;
            out_empty_reg <= 1'b1;
            out_full_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_idx_reg <= front_idx_next;
            rear_idx_reg  <= rear_idx_next;
            count_reg     <= count_next;
            front_val_reg <= front_val_next;
            rear_val_reg  <= rear_val_next;
            acc_reg       <= acc_next;
            ref_front_reg <= ref_front_next;
            ref_rear_reg  <= ref_rear_next;
            out_valid_reg <= out_valid_next;
            out_acc_reg   <= out_acc_next;
            out_front_reg <= out_front_next;
            out_rear_reg  <= out_rear_next;
            out_empty_reg <= out_empty_next;
            out_full_reg  <= out_full_next;
        end
    end

`ifndef SYNTHESIS
    // Count never exceeds the ring
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond ring depth");

    // A single entry sits at both ends
    a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_W'(1)) |-> (front_idx_reg == rear_idx_reg))
        else $error("front and rear differ with one entry");

    // No ring access while a result is pending
    a_no_access_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP) |-> !(mem_req.we || mem_req.re))
        else $error("ring access outside request cycle");

    // An accepted push grows the count by one
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !full_now
         && (req.mode == MODE_PUSH_FRONT || req.mode == MODE_PUSH_BACK))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not advance count");

    // A fresh result only follows the response state
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !rsp.ready))
        |-> $past(state_reg == ST_RESP))
        else $error("result without request");
`endif

endmodule
